// File: design/gtg_pkg.sv
package gtg_pkg;

    // Datapath widths
    localparam int CW = 38;            // CORDIC x/y width
    localparam int ZW = 21;            // CORDIC angle accumulator, Q.16
    localparam int AW = 17;            // angle width, Q3.13
    localparam int CORDIC_STEPS = 17;

    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 21'sd102944;
    localparam logic signed [17:0] PI_Q13 = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
    localparam logic [17:0] FINAL_TOL = 18'd819;
    localparam logic [48:0] SUM_MAX = 49'h0_FFFF_FFFF_FFFF;

    // Register indexes
    localparam logic [2:0] R_GOAL_X = 3'd0;
    localparam logic [2:0] R_GOAL_Y = 3'd1;
    localparam logic [2:0] R_GOAL_HEAD = 3'd2;
    localparam logic [2:0] R_PROP_GAIN = 3'd3;
    localparam logic [2:0] R_INT_GAIN = 3'd4;
    localparam logic [2:0] R_SPEED_LIM = 3'd5;
    localparam logic [2:0] R_ARRIVE = 3'd6;
    localparam logic [2:0] R_ALIGN_TOL = 3'd7;

    // Controller phases
    localparam logic [1:0] PH_ALIGN = 2'd0;
    localparam logic [1:0] PH_DRIVE = 2'd1;
    localparam logic [1:0] PH_FINAL = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_QMUL, ST_YAW_START, ST_YAW_WAIT, ST_DISPATCH,
        ST_BEAR_START, ST_BEAR_WAIT, ST_ALIGN, ST_SQMUL, ST_SQRT_START,
        ST_SQRT_WAIT, ST_SUM, ST_SPMUL, ST_DRIVE, ST_FINAL, ST_OUT
    } gtg_state_t;

    typedef enum logic [3:0] {
        MS_WZ, MS_XY, MS_YY, MS_ZZ, MS_MX, MS_MY, MS_KP, MS_KI_LO, MS_KI_HI, MS_NONE
    } gtg_mul_sel_t;

    // Handshake between the sequencer and an iterative unit
    typedef struct packed {
        logic start;
    } gtg_unit_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } gtg_unit_sts_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 21'sd51472;
            5'd1:    v = 21'sd30386;
            5'd2:    v = 21'sd16055;
            5'd3:    v = 21'sd8150;
            5'd4:    v = 21'sd4091;
            5'd5:    v = 21'sd2047;
            5'd6:    v = 21'sd1024;
            5'd7:    v = 21'sd512;
            5'd8:    v = 21'sd256;
            5'd9:    v = 21'sd128;
            5'd10:   v = 21'sd64;
            5'd11:   v = 21'sd32;
            5'd12:   v = 21'sd16;
            5'd13:   v = 21'sd8;
            5'd14:   v = 21'sd4;
            5'd15:   v = 21'sd2;
            5'd16:   v = 21'sd1;
            default: v = 21'sd0;
        endcase
        return v;
    endfunction

    // Brings an angle difference (well inside two turns) into [-pi, pi].
    function automatic logic signed [AW-1:0] wrap_angle(input logic signed [17:0] a);
        logic signed [17:0] r;
        r = a;
        if (a >= TWO_PI_Q13)
            r = a - TWO_PI_Q13;
        else if (a <= -TWO_PI_Q13)
            r = a + TWO_PI_Q13;
        if (r > PI_Q13)
            r = r - TWO_PI_Q13;
        else if (r < -PI_Q13)
            r = r + TWO_PI_Q13;
        return r[AW-1:0];
    endfunction

    function automatic logic [17:0] abs18(input logic signed [17:0] a);
        return a[17] ? 18'(-a) : 18'(a);
    endfunction

endpackage

// File: design/go_to_goal_pi_controller.sv
// Channel   Direction  Handshake             Beat contents
// in        receive    in_valid / in_stall   pos_x, pos_y, quat_x..quat_w
// out       send       out_valid / out_stall linear_speed, angular_rate, phase_code, last
// apb       slave      psel/penable/pready   eight control registers, 32-bit data
//
// A beat gives one command for each phase it runs: the aligning phase, driving and the final
// turn; a hand-over within the sample goes straight on into the next phase, and a sample in the
// done phase sends no command and frees the input. Each command also waits out out_stall, and
// the block returns to idle before the next beat is taken. Yaw and bearing come from the 17-step
// CORDIC unit and the distance from the 32-step square root, both iterating one step per cycle,
// and all products from one shared multiplier. Reset puts the block in the aligning phase with a
// cleared distance sum and the default register values. No input beat is taken while a sample is
// in work.
module go_to_goal_pi_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [30:0]        linear_speed,
    output logic signed [16:0] angular_rate,
    output logic [1:0]         phase_code,
    output logic               last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import gtg_pkg::*;

    // Control registers
    logic signed [31:0] goal_x_reg;
    logic signed [31:0] goal_y_reg;
    logic signed [15:0] goal_head_reg;
    logic [15:0]        prop_gain_reg;
    logic [15:0]        int_gain_reg;
    logic [30:0]        speed_lim_reg;
    logic [30:0]        arrive_reg;
    logic [14:0]        align_tol_reg;

    // Sequencer and controller state
    gtg_state_t         state_reg;
    gtg_state_t         state_next;
    logic [1:0]         phase_reg;
    logic [47:0]        dsum_reg;
    logic [1:0]         idx_reg;

    // Sample and intermediate values
    logic signed [32:0] dx_reg;
    logic signed [32:0] dy_reg;
    logic signed [15:0] qx_reg;
    logic signed [15:0] qy_reg;
    logic signed [15:0] qz_reg;
    logic signed [15:0] qw_reg;
    logic signed [32:0] num_reg;
    logic signed [32:0] den_reg;
    logic signed [AW-1:0] yaw_reg;
    logic signed [AW-1:0] bear_reg;
    logic [63:0]        sq_reg;
    logic [31:0]        dist_reg;
    logic [39:0]        kp_term_reg;
    logic [39:0]        ki_lo_reg;
    logic [39:0]        ki_hi_reg;

    // Output register
    logic               out_valid_reg;
    logic [30:0]        lin_reg;
    logic signed [16:0] ang_reg;
    logic [1:0]         code_reg;
    logic               last_reg;

    // Shared multiplier
    gtg_mul_sel_t       mul_sel;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod;

    // Iterative units
    gtg_unit_ctl_t      cor_ctl;
    gtg_unit_sts_t      cor_sts;
    gtg_unit_ctl_t      sq_ctl;
    gtg_unit_sts_t      sq_sts;
    logic signed [CW-1:0] cor_y;
    logic signed [CW-1:0] cor_x;
    logic signed [AW-1:0] cor_angle;
    logic [31:0]        sq_root;

    logic               in_acc;
    logic               out_acc;
    logic               cfg_wr;
    logic [30:0]        mx;
    logic [30:0]        my;
    logic [32:0]        adx;
    logic [32:0]        ady;
    logic signed [17:0] align_err;
    logic signed [17:0] final_err;
    logic [48:0]        dsum_add;
    logic [63:0]        speed_raw;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid_reg && !out_stall;
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg    <= 32'sd196608;
            goal_y_reg    <= 32'sd262144;
            goal_head_reg <= -16'sd12780;
            prop_gain_reg <= 16'd256;
            int_gain_reg  <= 16'd26;
            speed_lim_reg <= 31'd52429;
            arrive_reg    <= 31'd32768;
            align_tol_reg <= 15'd410;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                R_GOAL_X:    goal_x_reg    <= pwdata;
                R_GOAL_Y:    goal_y_reg    <= pwdata;
                R_GOAL_HEAD: goal_head_reg <= pwdata[15:0];
                R_PROP_GAIN: prop_gain_reg <= pwdata[15:0];
                R_INT_GAIN:  int_gain_reg  <= pwdata[15:0];
                R_SPEED_LIM: speed_lim_reg <= pwdata[30:0];
                R_ARRIVE:    arrive_reg    <= pwdata[30:0];
                R_ALIGN_TOL: align_tol_reg <= pwdata[14:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            R_GOAL_X:    prdata = goal_x_reg;
            R_GOAL_Y:    prdata = goal_y_reg;
            R_GOAL_HEAD: prdata = {{16{goal_head_reg[15]}}, goal_head_reg};
            R_PROP_GAIN: prdata = {16'd0, prop_gain_reg};
            R_INT_GAIN:  prdata = {16'd0, int_gain_reg};
            R_SPEED_LIM: prdata = {1'b0, speed_lim_reg};
            R_ARRIVE:    prdata = {1'b0, arrive_reg};
            R_ALIGN_TOL: prdata = {17'd0, align_tol_reg};
            default:     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:       if (in_valid) state_next = ST_QMUL;
            ST_QMUL:       if (idx_reg == 2'd3) state_next = ST_YAW_START;
            ST_YAW_START:  state_next = ST_YAW_WAIT;
            ST_YAW_WAIT:   if (cor_sts.done) state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                case (phase_reg)
                    PH_ALIGN: state_next = ST_BEAR_START;
                    PH_DRIVE: state_next = ST_SQMUL;
                    PH_FINAL: state_next = ST_FINAL;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_BEAR_START: state_next = ST_BEAR_WAIT;
            ST_BEAR_WAIT:  if (cor_sts.done) state_next = ST_ALIGN;
            ST_ALIGN:      state_next = ST_OUT;
            ST_SQMUL:      if (idx_reg == 2'd1) state_next = ST_SQRT_START;
            ST_SQRT_START: state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT:  if (sq_sts.done) state_next = ST_SUM;
            ST_SUM:        state_next = ST_SPMUL;
            ST_SPMUL:      if (idx_reg == 2'd2) state_next = ST_DRIVE;
            ST_DRIVE:      state_next = ST_OUT;
            ST_FINAL:      state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_acc)
                begin
                    if (last_reg)
                        state_next = ST_IDLE;
                    else if (phase_reg == PH_DRIVE)
                        state_next = ST_SQMUL;
                    else
                        state_next = ST_FINAL;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: unit controls
    // ---------------------------------------------------------------
    always_comb
    begin
        cor_ctl.start = 1'b0;
        sq_ctl.start  = 1'b0;
        mul_sel       = MS_NONE;
        cor_y         = CW'(dy_reg);
        cor_x         = CW'(dx_reg);
        case (state_reg)
            ST_QMUL:
            begin
                case (idx_reg)
                    2'd0:    mul_sel = MS_WZ;
                    2'd1:    mul_sel = MS_XY;
                    2'd2:    mul_sel = MS_YY;
                    default: mul_sel = MS_ZZ;
                endcase
            end
            ST_YAW_START:
            begin
                cor_ctl.start = 1'b1;
                cor_y = CW'(num_reg) <<< 1;
                cor_x = (CW'(1) <<< 28) - (CW'(den_reg) <<< 1);
            end
            ST_BEAR_START: cor_ctl.start = 1'b1;
            ST_SQMUL:      mul_sel = (idx_reg == 2'd0) ? MS_MX : MS_MY;
            ST_SQRT_START: sq_ctl.start = 1'b1;
            ST_SPMUL:
            begin
                case (idx_reg)
                    2'd0:    mul_sel = MS_KP;
                    2'd1:    mul_sel = MS_KI_LO;
                    default: mul_sel = MS_KI_HI;
                endcase
            end
            default:       ;
        endcase
    end

    // Distance offsets saturate for the magnitude only.
    assign adx = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign ady = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
    assign mx  = (adx > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : adx[30:0];
    assign my  = (ady > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : ady[30:0];

    always_comb
    begin
        case (mul_sel)
            MS_WZ:    begin mul_a = 33'(qw_reg); mul_b = 33'(qz_reg); end
            MS_XY:    begin mul_a = 33'(qx_reg); mul_b = 33'(qy_reg); end
            MS_YY:    begin mul_a = 33'(qy_reg); mul_b = 33'(qy_reg); end
            MS_ZZ:    begin mul_a = 33'(qz_reg); mul_b = 33'(qz_reg); end
            MS_MX:    begin mul_a = {2'b00, mx}; mul_b = {2'b00, mx}; end
            MS_MY:    begin mul_a = {2'b00, my}; mul_b = {2'b00, my}; end
            MS_KP:    begin mul_a = {17'd0, prop_gain_reg}; mul_b = {1'b0, dist_reg}; end
            MS_KI_LO: begin mul_a = {17'd0, int_gain_reg}; mul_b = {9'd0, dsum_reg[23:0]}; end
            MS_KI_HI: begin mul_a = {17'd0, int_gain_reg}; mul_b = {9'd0, dsum_reg[47:24]}; end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Angle errors: the tolerance tests use these unwrapped.
    assign align_err = 18'(bear_reg) - 18'(yaw_reg);
    assign final_err = 18'(goal_head_reg) - 18'(yaw_reg);
    assign dsum_add  = {1'b0, dsum_reg} + 49'(dist_reg);
    assign speed_raw = 64'(kp_term_reg)
                     + 64'((({24'd0, ki_hi_reg} << 24) + 64'(ki_lo_reg)) >> 8);

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_ALIGN;
            dsum_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
                idx_reg <= '0;
            else
                idx_reg <= idx_reg + 2'd1;
            case (state_reg)
                ST_ALIGN:
                begin
                    out_valid_reg <= 1'b1;
                    if (abs18(align_err) <= 18'(align_tol_reg))
                        phase_reg <= PH_DRIVE;
                end
                ST_SUM:
                begin
                    dsum_reg <= (dsum_add > SUM_MAX) ? SUM_MAX[47:0] : dsum_add[47:0];
                end
                ST_DRIVE:
                begin
                    out_valid_reg <= 1'b1;
                    if (dist_reg < 32'(arrive_reg))
                    begin
                        phase_reg <= PH_FINAL;
                        dsum_reg  <= '0;
                    end
                end
                ST_FINAL:
                begin
                    out_valid_reg <= 1'b1;
                    if (abs18(final_err) <= FINAL_TOL)
                        phase_reg <= PH_DONE;
                end
                ST_OUT:
                begin
                    if (out_acc)
                        out_valid_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            dx_reg <= 33'(goal_x_reg) - 33'(pos_x);
            dy_reg <= 33'(goal_y_reg) - 33'(pos_y);
            qx_reg <= quat_x;
            qy_reg <= quat_y;
            qz_reg <= quat_z;
            qw_reg <= quat_w;
        end
        case (state_reg)
            ST_QMUL:
            begin
                case (idx_reg)
                    2'd0:    num_reg <= prod[32:0];
                    2'd1:    num_reg <= num_reg + prod[32:0];
                    2'd2:    den_reg <= prod[32:0];
                    default: den_reg <= den_reg + prod[32:0];
                endcase
            end
            ST_YAW_WAIT:  if (cor_sts.done) yaw_reg <= cor_angle;
            ST_BEAR_WAIT: if (cor_sts.done) bear_reg <= cor_angle;
            ST_SQMUL:
            begin
                if (idx_reg == 2'd0)
                    sq_reg <= prod[63:0];
                else
                    sq_reg <= sq_reg + prod[63:0];
            end
            ST_SQRT_WAIT: if (sq_sts.done) dist_reg <= sq_root;
            ST_SPMUL:
            begin
                case (idx_reg)
                    2'd0:    kp_term_reg <= prod[47:8];
                    2'd1:    ki_lo_reg   <= prod[39:0];
                    default: ki_hi_reg   <= prod[39:0];
                endcase
            end
            ST_ALIGN:
            begin
                lin_reg  <= '0;
                ang_reg  <= wrap_angle(align_err);
                code_reg <= PH_ALIGN;
                last_reg <= !(abs18(align_err) <= 18'(align_tol_reg));
            end
            ST_DRIVE:
            begin
                lin_reg  <= (speed_raw > 64'(speed_lim_reg)) ? speed_lim_reg
                                                            : speed_raw[30:0];
                ang_reg  <= '0;
                code_reg <= PH_DRIVE;
                last_reg <= !(dist_reg < 32'(arrive_reg));
            end
            ST_FINAL:
            begin
                lin_reg  <= '0;
                ang_reg  <= wrap_angle(final_err);
                code_reg <= PH_FINAL;
                last_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    gtg_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cor_ctl),
        .y_in  (cor_y),
        .x_in  (cor_x),
        .sts   (cor_sts),
        .angle (cor_angle)
    );

    gtg_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sq_ctl),
        .value (sq_reg),
        .sts   (sq_sts),
        .root  (sq_root)
    );

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign linear_speed = lin_reg;
    assign angular_rate = ang_reg;
    assign phase_code   = code_reg;
    assign last         = last_reg;

    // A new sample is only taken once every command of the previous one is gone.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid_reg)
        else $error("input accepted with a command pending");

    a_drive_no_turn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && code_reg == PH_DRIVE |-> ang_reg == '0)
        else $error("turn rate commanded while driving");

    a_turn_no_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && code_reg != PH_DRIVE |-> lin_reg == '0)
        else $error("speed commanded while turning");

    a_speed_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> lin_reg <= speed_lim_reg)
        else $error("speed above limit");

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cor_sts.busy && sq_sts.busy))
        else $error("shared units active together");

endmodule

// File: design/gtg_cordic.sv
module gtg_cordic (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gtg_pkg::gtg_unit_ctl_t       ctl,
    input  logic signed [gtg_pkg::CW-1:0] y_in,
    input  logic signed [gtg_pkg::CW-1:0] x_in,
    output gtg_pkg::gtg_unit_sts_t       sts,
    output logic signed [gtg_pkg::AW-1:0] angle
);
    import gtg_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic                 zero_reg;
    logic [4:0]           step_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] zr;

    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign zr = (z_reg + ZW'(4)) >>> 3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && step_reg == 5'(CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            step_reg <= 5'd0;
            zero_reg <= (x_in == '0) && (y_in == '0);
            // Vectors in the left half-plane are first turned by a quarter turn.
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_reg <= y_in;
                    y_reg <= -x_in;
                    z_reg <= HALF_PI_Q16;
                end
                else
                begin
                    x_reg <= -y_in;
                    y_reg <= x_in;
                    z_reg <= -HALF_PI_Q16;
                end
            end
            else
            begin
                x_reg <= x_in;
                y_reg <= y_in;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 5'd1;
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_entry(step_reg);
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_entry(step_reg);
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign angle = zero_reg ? '0 : zr[AW-1:0];

endmodule

// File: design/gtg_isqrt.sv
module gtg_isqrt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gtg_pkg::gtg_unit_ctl_t ctl,
    input  logic [63:0]            value,
    output gtg_pkg::gtg_unit_sts_t sts,
    output logic [31:0]            root
);
    import gtg_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg == 64'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // One result bit per cycle, the radicand never exceeds 2^63.
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            v_reg   <= value;
            res_reg <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign root = res_reg[31:0];

endmodule
